>>> rtl/slva_pkg.sv
// Package for the semi-Lagrangian velocity advection unit.
// Request/response payload types, sequencer states and fixed-point constants.
// No dependencies.
`default_nettype none

package slva_pkg;

   localparam int STEP_LIM = 65470;
   localparam int ONE_Q16  = 65536;
   localparam logic [63:0] MAG_LIM = 64'd1000000 << 32;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_ADVECT = 1'b1;

   typedef struct packed {
      logic               kind;
      logic [3:0]         pos_x;
      logic [3:0]         pos_y;
      logic [3:0]         pos_z;
      logic signed [31:0] vel_u;
      logic signed [31:0] vel_v;
      logic signed [31:0] vel_w;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] adv_u;
      logic signed [31:0] adv_v;
      logic signed [31:0] adv_w;
      logic               too_fast;
      logic               bad_cell;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CEN,
      ST_SCL,
      ST_TRC,
      ST_WXY,
      ST_WT,
      ST_RND,
      ST_MAC,
      ST_ACC,
      ST_RES,
      ST_SQ,
      ST_MAG,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> rtl/semi_lagrangian_velocity_advection_unit.sv
// Semi-Lagrangian velocity advection unit, top level.
// Three velocity grids in single-port memories, one shared multiplier under a sequencer.
// Depends on slva_pkg.
//
// Usage:
//  - Request channel (req_valid/req_stall/req_payload): kind 0 writes one cell of the
//    three grids; kind 1 asks for the advected velocity at a cell.
//  - Response channel (rsp_valid/rsp_stall/rsp_payload): one response per advect
//    request, none per write. A response sits in an output register until taken.
//  - csr_write_en/csr_write_data load step_scale (unsigned Q8.16); the user must do
//    so only while idle, as the block itself does not enforce it.
//  - An interior advect reads the center cell, traces the three axes, then for each
//    of 8 corners forms the weight products and three multiply-accumulates, then
//    rounds and squares each component and loads the output register.
//    Every product runs through the one multiplier.
//    A non-interior cell skips these steps and answers with bad_cell.
//  - req_stall is high while an advect is in progress. A write may be taken while
//    a response still waits; a finished advect holds until the output register frees.
//  - Reset clears the sequencer, the response valid and sets step_scale to 1.0.
//    Grid contents are undefined until written.
`default_nettype none

module semi_lagrangian_velocity_advection_unit
   import slva_pkg::*;
#(
   parameter int GRID_DIM = 16
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload,
   input  wire logic            csr_write_en,
   input  wire logic [23:0]     csr_write_data
);

   localparam int LW    = $clog2(GRID_DIM);
   localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
   localparam int AW    = $clog2(CELLS);

   function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] x,
                                                input logic [AW-1:0] y,
                                                input logic [AW-1:0] z);
      cell_addr = x + y * AW'(GRID_DIM) + z * AW'(GRID_DIM * GRID_DIM);
   endfunction

   state_type state_ff, state_in;

   logic [23:0]        scale_ff;
   logic [1:0]         idx_ff, idx_in;
   logic [2:0]         corner_ff, corner_in;
   logic               rsp_valid_ff;
   rsp_payload_type    rsp_ff;

   logic [3:0]         cx_ff, cy_ff, cz_ff;
   logic signed [31:0] vel_ff [3];
   logic [LW-1:0]      lo_ff [3];
   logic [16:0]        f1_ff [3];
   logic [24:0]        wt_ff;
   logic signed [59:0] acc_ff [3];
   logic signed [31:0] res_ff [3];
   logic [63:0]        mag_ff;
   logic               bad_ff;
   logic signed [67:0] mul_p_ff;

   logic [31:0] grid_u_ff [CELLS];
   logic [31:0] grid_v_ff [CELLS];
   logic [31:0] grid_w_ff [CELLS];
   logic signed [31:0] rd_ff [3];

   logic               mem_we;
   logic [AW-1:0]      mem_addr;
   logic signed [34:0] mul_a;
   logic signed [32:0] mul_b;
   logic               rsp_load;

   logic               req_inside;
   logic               req_interior;
   logic [AW-1:0]      req_addr;
   logic [AW-1:0]      ctr_addr;
   logic [AW-1:0]      cor_addr;
   logic [16:0]        wx, wy, wz;
   logic [3:0]         trc_c;
   logic signed [51:0] d_full;
   logic signed [17:0] d_cl;
   logic signed [23:0] p_pos;
   logic signed [7:0]  k_raw;
   logic [7:0]         k_cl;
   logic signed [24:0] fr;
   logic [16:0]        fr_cl;
   logic signed [35:0] res_sh;
   logic signed [31:0] res_sat;
   logic [31:0]        res_abs;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign req_inside = (int'(req_payload.pos_x) < GRID_DIM) &&
                       (int'(req_payload.pos_y) < GRID_DIM) &&
                       (int'(req_payload.pos_z) < GRID_DIM);
   assign req_interior = (req_payload.pos_x != 4'd0) && (req_payload.pos_y != 4'd0) &&
                         (req_payload.pos_z != 4'd0) &&
                         (int'(req_payload.pos_x) <= GRID_DIM - 2) &&
                         (int'(req_payload.pos_y) <= GRID_DIM - 2) &&
                         (int'(req_payload.pos_z) <= GRID_DIM - 2);
   assign req_addr = cell_addr(AW'(req_payload.pos_x), AW'(req_payload.pos_y),
                               AW'(req_payload.pos_z));
   assign ctr_addr = cell_addr(AW'(cx_ff), AW'(cy_ff), AW'(cz_ff));
   assign cor_addr = cell_addr(AW'(lo_ff[0] + LW'(corner_ff[0])),
                               AW'(lo_ff[1] + LW'(corner_ff[1])),
                               AW'(lo_ff[2] + LW'(corner_ff[2])));

   assign wx = corner_ff[0] ? f1_ff[0] : 17'(ONE_Q16) - f1_ff[0];
   assign wy = corner_ff[1] ? f1_ff[1] : 17'(ONE_Q16) - f1_ff[1];
   assign wz = corner_ff[2] ? f1_ff[2] : 17'(ONE_Q16) - f1_ff[2];

   // backtrace of one axis from the registered velocity product
   always_comb begin
      case (idx_ff)
         2'd0:    trc_c = cx_ff;
         2'd1:    trc_c = cy_ff;
         default: trc_c = cz_ff;
      endcase
      d_full = mul_p_ff[67:16];
      if (d_full > signed'(52'(STEP_LIM))) begin
         d_cl = 18'(STEP_LIM);
      end else if (d_full < -signed'(52'(STEP_LIM))) begin
         d_cl = -18'(STEP_LIM);
      end else begin
         d_cl = d_full[17:0];
      end
      p_pos = signed'({4'd0, trc_c, 16'd0}) - 24'(d_cl);
      k_raw = p_pos[23:16];
      if (k_raw < 0) begin
         k_cl = 8'd0;
      end else if (int'(k_raw) > GRID_DIM - 2) begin
         k_cl = 8'(GRID_DIM - 2);
      end else begin
         k_cl = k_raw;
      end
      fr = 25'(p_pos) - signed'({1'b0, k_cl, 16'd0});
      if (fr < 0) begin
         fr_cl = 17'd0;
      end else if (fr > 25'sd65536) begin
         fr_cl = 17'(ONE_Q16);
      end else begin
         fr_cl = fr[16:0];
      end
   end

   always_comb begin
      res_sh = 36'((acc_ff[idx_ff] + 60'sd8388608) >>> 24);
      if (res_sh > 36'sd2147483647) begin
         res_sat = 32'sh7fffffff;
      end else if (res_sh < -36'sd2147483648) begin
         res_sat = 32'sh80000000;
      end else begin
         res_sat = res_sh[31:0];
      end
      res_abs = res_ff[idx_ff][31] ? 32'(-res_ff[idx_ff]) : res_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= 2'd0;
         corner_ff <= 3'd0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         corner_ff <= corner_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      corner_in = corner_ff;
      req_stall = 1'b1;
      mem_we    = 1'b0;
      mem_addr  = ctr_addr;
      mul_a     = '0;
      mul_b     = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_addr  = req_addr;
            if (req_valid) begin
               if (req_payload.kind == KIND_WRITE) begin
                  mem_we = req_inside;
               end else if (req_interior) begin
                  state_in = ST_CEN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_CEN: begin
            idx_in   = 2'd0;
            state_in = ST_SCL;
         end
         ST_SCL: begin
            mul_a    = 35'(vel_ff[idx_ff]);
            mul_b    = signed'({9'd0, scale_ff});
            state_in = ST_TRC;
         end
         ST_TRC: begin
            if (idx_ff == 2'd2) begin
               corner_in = 3'd0;
               state_in  = ST_WXY;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_SCL;
            end
         end
         ST_WXY: begin
            mem_addr = cor_addr;
            mul_a    = signed'({18'd0, wx});
            mul_b    = signed'({16'd0, wy});
            state_in = ST_WT;
         end
         ST_WT: begin
            mem_addr = cor_addr;
            mul_a    = signed'({1'b0, mul_p_ff[33:0]});
            mul_b    = signed'({16'd0, wz});
            state_in = ST_RND;
         end
         ST_RND: begin
            mem_addr = cor_addr;
            idx_in   = 2'd0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            mem_addr = cor_addr;
            mul_a    = signed'({10'd0, wt_ff});
            mul_b    = 33'(rd_ff[idx_ff]);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            mem_addr = cor_addr;
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               if (corner_ff == 3'd7) begin
                  state_in = ST_RES;
               end else begin
                  corner_in = corner_ff + 3'd1;
                  state_in  = ST_WXY;
               end
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_MAC;
            end
         end
         ST_RES: begin
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a    = signed'({3'd0, res_abs});
            mul_b    = signed'({1'b0, res_abs});
            state_in = ST_MAG;
         end
         ST_MAG: begin
            if (idx_ff == 2'd2) begin
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_RES;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // grid memories, one shared address each cycle for a write and a registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_u_ff[mem_addr] <= req_payload.vel_u;
         grid_v_ff[mem_addr] <= req_payload.vel_v;
         grid_w_ff[mem_addr] <= req_payload.vel_w;
      end
      rd_ff[0] <= grid_u_ff[mem_addr];
      rd_ff[1] <= grid_v_ff[mem_addr];
      rd_ff[2] <= grid_w_ff[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= 24'd65536;
      end else if (csr_write_en) begin
         scale_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.adv_u    <= res_ff[0];
         rsp_ff.adv_v    <= res_ff[1];
         rsp_ff.adv_w    <= res_ff[2];
         rsp_ff.too_fast <= !bad_ff && (mag_ff > MAG_LIM);
         rsp_ff.bad_cell <= bad_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mul_p_ff <= 68'(mul_a) * 68'(mul_b);
      case (state_ff)
         ST_IDLE: begin
            cx_ff  <= req_payload.pos_x;
            cy_ff  <= req_payload.pos_y;
            cz_ff  <= req_payload.pos_z;
            bad_ff <= !req_interior;
            mag_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               acc_ff[i] <= '0;
               res_ff[i] <= '0;
            end
         end
         ST_CEN: begin
            for (int i = 0; i < 3; i++) begin
               vel_ff[i] <= rd_ff[i];
            end
         end
         ST_TRC: begin
            lo_ff[idx_ff] <= LW'(k_cl);
            f1_ff[idx_ff] <= fr_cl;
         end
         ST_RND: begin
            wt_ff <= 25'((mul_p_ff[50:0] + 51'd8388608) >> 24);
         end
         ST_ACC: begin
            acc_ff[idx_ff] <= acc_ff[idx_ff] + 60'(mul_p_ff);
         end
         ST_RES: begin
            res_ff[idx_ff] <= res_sat;
         end
         ST_MAG: begin
            mag_ff <= mag_ff + mul_p_ff[63:0];
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for semi_lagrangian_velocity_advection_unit: grid writes and advect requests
// checked against an in-bench fixed-point model of the trilinear backtrace.
// Depends on slva_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb_top
   import slva_pkg::*;
();

   localparam int DIM = 16;
   localparam int CELLS = DIM * DIM * DIM;
   localparam int MAX_CYCLES = 2000000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_write_en = 1'b0;
   logic [23:0]     csr_write_data = '0;

   semi_lagrangian_velocity_advection_unit #(.GRID_DIM(DIM)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   logic signed [31:0] vel_u_mem [CELLS];
   logic signed [31:0] vel_v_mem [CELLS];
   logic signed [31:0] vel_w_mem [CELLS];
   logic [23:0]        step_scale_q = 24'd65536;
   rsp_payload_type    advect_queue [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   bit                 idle_enable = 1'b1;

   function automatic int cell_of(int x, int y, int z);
      return x + y * DIM + z * DIM * DIM;
   endfunction

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   task automatic trace(input int c, input logic signed [31:0] vel,
                        output int lo, output longint frac);
      longint d, p, k;
      d = floor_sh(longint'(vel) * longint'({8'd0, step_scale_q}), 16);
      if (d > STEP_LIM) d = STEP_LIM;
      if (d < -STEP_LIM) d = -STEP_LIM;
      p = longint'(c) * ONE_Q16 - d;
      k = floor_sh(p, 16);
      if (k < 0) k = 0;
      if (k > DIM - 2) k = DIM - 2;
      lo = int'(k);
      p = p - k * ONE_Q16;
      if (p < 0) p = 0;
      if (p > ONE_Q16) p = ONE_Q16;
      frac = p;
   endtask

   task automatic advect_predict(input int x, input int y, input int z,
                                 output rsp_payload_type r);
      int lo [3];
      longint f [3];
      longint acc [3];
      longint wx, wy, wz, wt, v, a;
      logic [63:0] mag;
      logic signed [31:0] res [3];
      int ci, k;
      r = '0;
      if (x < 1 || y < 1 || z < 1 || x > DIM - 2 || y > DIM - 2 || z > DIM - 2) begin
         r.bad_cell = 1'b1;
         return;
      end
      ci = cell_of(x, y, z);
      trace(x, vel_u_mem[ci], lo[0], f[0]);
      trace(y, vel_v_mem[ci], lo[1], f[1]);
      trace(z, vel_w_mem[ci], lo[2], f[2]);
      acc = '{0, 0, 0};
      for (int i = 0; i < 8; i++) begin
         wx = i[0] ? f[0] : ONE_Q16 - f[0];
         wy = i[1] ? f[1] : ONE_Q16 - f[1];
         wz = i[2] ? f[2] : ONE_Q16 - f[2];
         wt = longint'((64'(wx) * 64'(wy) * 64'(wz) + 64'h800000) >> 24);
         k = cell_of(lo[0] + i[0], lo[1] + i[1], lo[2] + i[2]);
         acc[0] += wt * longint'(vel_u_mem[k]);
         acc[1] += wt * longint'(vel_v_mem[k]);
         acc[2] += wt * longint'(vel_w_mem[k]);
      end
      mag = 0;
      for (int i = 0; i < 3; i++) begin
         v = floor_sh(acc[i] + 64'sh800000, 24);
         if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
         if (v < -64'sh80000000) v = -64'sh80000000;
         res[i] = v[31:0];
         a = v < 0 ? -v : v;
         mag += 64'(a) * 64'(a);
      end
      r.adv_u = res[0];
      r.adv_v = res[1];
      r.adv_w = res[2];
      r.too_fast = mag > MAG_LIM;
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (advect_queue.size() == 0) begin
            report("unexpected response", 0, 0);
         end else begin
            e = advect_queue.pop_front();
            if (rsp_payload.adv_u !== e.adv_u) report("adv_u", rsp_payload.adv_u, e.adv_u);
            if (rsp_payload.adv_v !== e.adv_v) report("adv_v", rsp_payload.adv_v, e.adv_v);
            if (rsp_payload.adv_w !== e.adv_w) report("adv_w", rsp_payload.adv_w, e.adv_w);
            if (rsp_payload.too_fast !== e.too_fast)
               report("too_fast", rsp_payload.too_fast, e.too_fast);
            if (rsp_payload.bad_cell !== e.bad_cell)
               report("bad_cell", rsp_payload.bad_cell, e.bad_cell);
         end
      end
   end

   // receiver stalls in random bursts while idle_enable is set
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (idle_enable && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   task automatic send(input req_payload_type p);
      rsp_payload_type r;
      int ci;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (p.kind == KIND_WRITE) begin
         ci = cell_of(p.pos_x, p.pos_y, p.pos_z);
         vel_u_mem[ci] = p.vel_u;
         vel_v_mem[ci] = p.vel_v;
         vel_w_mem[ci] = p.vel_w;
      end else begin
         advect_predict(p.pos_x, p.pos_y, p.pos_z, r);
         advect_queue.push_back(r);
      end
   endtask

   task automatic write_cell(input int x, input int y, input int z,
                             input logic [31:0] u, input logic [31:0] v, input logic [31:0] w);
      req_payload_type p;
      p = '{KIND_WRITE, x[3:0], y[3:0], z[3:0], u, v, w};
      send(p);
   endtask

   task automatic advect(input int x, input int y, input int z);
      req_payload_type p;
      p = '{KIND_ADVECT, x[3:0], y[3:0], z[3:0], $urandom, $urandom, $urandom};
      send(p);
   endtask

   // one coordinate on the grid border, so the unit answers bad_cell without tracing
   task automatic advect_edge();
      int c [3];
      int k;
      for (int j = 0; j < 3; j++) c[j] = $urandom_range(0, 15);
      k = $urandom_range(0, 2);
      c[k] = $urandom_range(0, 1) ? 0 : 15;
      advect(c[0], c[1], c[2]);
   endtask

   // interior cell inside one of the two filled boxes
   task automatic advect_box();
      int base;
      base = $urandom_range(0, 1) ? 0 : 11;
      advect(base + $urandom_range(1, 3), base + $urandom_range(1, 3),
             base + $urandom_range(1, 3));
   endtask

   function automatic logic [31:0] rand_vel();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'(int'($urandom_range(0, 131072)) - 65536);
         2: return 32'h7FFFFFFF;
         3: return 32'h80000000;
         default: return 32'(int'($urandom_range(0, 8000000)) - 4000000);
      endcase
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (advect_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_step(input logic [23:0] s);
      drain();
      csr_write_en <= 1'b1;
      csr_write_data <= s;
      @(posedge clock);
      csr_write_en <= 1'b0;
      step_scale_q = s;
   endtask

   // advects stay in two corner boxes; filling both keeps every read corner written
   task automatic test_fill_grid();
      for (int b = 0; b < 2; b++)
         for (int z = 0; z < 5; z++)
            for (int y = 0; y < 5; y++)
               for (int x = 0; x < 5; x++)
                  write_cell(b * 11 + x, b * 11 + y, b * 11 + z,
                             rand_vel(), rand_vel(), rand_vel());
   endtask

   task automatic test_directed();
      write_cell(1, 1, 1, 32'h7FFFFFFF, 32'h80000000, 32'h0);
      advect(1, 1, 1);
      write_cell(14, 14, 14, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
      advect(14, 14, 14);
      write_cell(12, 12, 12, 32'h0, 32'h0, 32'h0);
      advect(12, 12, 12);
      advect(0, 5, 5);
      advect(5, 15, 5);
      advect(5, 5, 0);
      advect(15, 15, 15);
      write_cell(2, 2, 2, 32'h3E800000, 32'h3E800000, 32'h3E800000);
      write_cell(3, 2, 2, 32'h3E800000, 32'h3E800000, 32'h3E800000);
      write_cell(2, 3, 2, 32'hC1800000, 32'h3E800000, 32'h3E800000);
      write_cell(2, 2, 3, 32'h3E800000, 32'hC1800000, 32'h3E800000);
      write_cell(3, 3, 3, 32'h3E800000, 32'h3E800000, 32'h3E800000);
      advect(2, 2, 2);
      advect(3, 3, 3);
      advect(2, 3, 2);
   endtask

   task automatic test_random(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 2) == 0)
            write_cell($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
                       rand_vel(), rand_vel(), rand_vel());
         else if ($urandom_range(0, 9) == 0)
            advect_edge();
         else
            advect_box();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_grid();
      test_directed();
      test_random(130);
      set_step(24'd0);
      test_random(130);
      set_step(24'hFFFFFF);
      test_directed();
      test_random(130);
      set_step(24'd1);
      test_random(100);
      set_step(24'd16384);
      test_random(130);
      set_step(24'd65536);
      idle_enable = 1'b0;
      test_random(130);
      drain();
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
rtl/slva_pkg.sv
rtl/semi_lagrangian_velocity_advection_unit.sv
tb/sv/tb_top.sv
